// File: rtl/epap_pkg.sv
// shared constants, register map and sine table generator for the equal-power auto panner
package epap_pkg;

    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam int GAIN_W    = 17;

    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEPTH_GAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_PHASE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WET_MIX     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE = 3'd4;

    localparam logic [23:0] PHASE_STEP_RST  = 24'd89478;
    localparam logic [16:0] DEPTH_GAIN_RST  = 17'd65536;
    localparam logic [31:0] START_PHASE_RST = 32'd0;
    localparam logic [16:0] WET_MIX_RST     = 17'd65536;
    localparam logic        STEREO_MODE_RST = 1'b1;

    localparam logic [16:0] Q16_ONE       = 17'd65536;
    localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;

    // two q30 multiplies by x
    function automatic logic [63:0] sine_next_term(input logic [63:0] t, input logic [63:0] x);
        logic [63:0] p;
        p = (t * x) >> 30;
        return (p * x) >> 30;
    endfunction

    // quarter-wave sine entry k of 2^bits, taylor series in q2.30, rounded to q1.16
    function automatic logic [GAIN_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        t;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x   = (HALF_PI_Q30 * 64'(k)) >> bits;
        t   = sine_next_term(x, x) / 64'd6;
        sum = $signed(x) - $signed(t);
        t   = sine_next_term(t, x) / 64'd20;
        sum = sum + $signed(t);
        t   = sine_next_term(t, x) / 64'd42;
        sum = sum - $signed(t);
        t   = sine_next_term(t, x) / 64'd72;
        sum = sum + $signed(t);
        t   = sine_next_term(t, x) / 64'd110;
        sum = sum - $signed(t);
        t   = sine_next_term(t, x) / 64'd156;
        sum = sum + $signed(t);
        t   = sine_next_term(t, x) / 64'd210;
        sum = sum - $signed(t);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = (64'(sum) + 64'd8192) >> 14;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return r[GAIN_W-1:0];
    endfunction

endpackage

// File: rtl/equal_power_auto_panner.sv
// top level of the lfo auto panner with equal-power gains
//
// Input words (left, right, block_last) arrive on the s_ valid/ready channel,
// panned and mixed words leave on the m_ valid/ready channel. Settings are
// written over the APB port (phase step, depth, start phase, wet mix, stereo).
// Between acceptance and the output register, a small sequencer walks one
// shared signed multiplier through the lfo depth scaling, the gain products and
// the wet/dry mix, and the sine table is read through one registered port three
// times per word. s_ready is high only while the sequencer is idle, so one word
// is in work at a time; a finished word sits in the output register while the
// next word is accepted. If the receiver stalls, the sequencer holds its
// result until the output register frees up, and the lfo phase advances when
// it is handed over.
// Reset loads the register defaults and sets the lfo phase to the start phase;
// a write to start_phase reloads the phase as well.
module equal_power_auto_panner #(
    parameter int SINE_TABLE_BITS = 8,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [epap_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]      s_right_in,
    input  logic                               s_block_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_left_out,
    output logic signed [SAMPLE_BITS-1:0]      m_right_out,
    output logic                               m_block_last_out
);
    import epap_pkg::*;

    localparam int TB  = SINE_TABLE_BITS;
    localparam int AW  = TB + 1;
    localparam int W   = SAMPLE_BITS;
    localparam int OPW = (W + 2 > 19) ? W + 2 : 19;
    localparam int PW  = 2 * OPW;
    localparam int ACW = PW + 1;

    localparam logic [AW-1:0]         TBL_N  = AW'(1) << TB;
    localparam logic signed [PW-1:0]  HALF15 = PW'(1) << 15;
    localparam logic signed [PW-1:0]  HALF16 = PW'(1) << 16;
    localparam logic signed [ACW-1:0] HALF_A = ACW'(1) << 15;
    localparam logic signed [ACW-1:0] SAT_HI = (ACW'(1) << (W - 1)) - ACW'(1);
    localparam logic signed [ACW-1:0] SAT_LO = -(ACW'(1) << (W - 1));

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_LFO  = 5'd1;
    localparam logic [4:0] ST_PAN  = 5'd2;
    localparam logic [4:0] ST_GR   = 5'd3;
    localparam logic [4:0] ST_GL   = 5'd4;
    localparam logic [4:0] ST_GAIN = 5'd5;
    localparam logic [4:0] ST_YL   = 5'd6;
    localparam logic [4:0] ST_YR   = 5'd7;
    localparam logic [4:0] ST_L1   = 5'd8;
    localparam logic [4:0] ST_L2   = 5'd9;
    localparam logic [4:0] ST_L3   = 5'd10;
    localparam logic [4:0] ST_R1   = 5'd11;
    localparam logic [4:0] ST_R2   = 5'd12;
    localparam logic [4:0] ST_MG   = 5'd13;
    localparam logic [4:0] ST_MY1  = 5'd14;
    localparam logic [4:0] ST_MY2  = 5'd15;
    localparam logic [4:0] ST_DONE = 5'd16;

    // configuration
    logic [23:0]          phase_step_reg;
    logic [16:0]          depth_reg;
    logic [31:0]          start_phase_reg;
    logic [16:0]          wet_reg;
    logic                 stereo_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // sequencer and datapath
    logic [4:0]             state_reg;
    logic [4:0]             state_next;
    logic [31:0]            phase_reg;
    logic signed [W-1:0]    xl_reg;
    logic signed [W-1:0]    xr_reg;
    logic                   last_reg;
    logic [AW-1:0]          idx_reg;
    logic [GAIN_W-1:0]      gr_reg;
    logic signed [OPW-1:0]  yl_reg;
    logic signed [OPW-1:0]  yr_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACW-1:0]  acc_reg;
    logic signed [W-1:0]    outl_reg;
    logic signed [W-1:0]    outr_reg;
    logic                   m_valid_reg;
    logic signed [W-1:0]    m_left_reg;
    logic signed [W-1:0]    m_right_reg;
    logic                   m_last_reg;

    logic [16:0]            depth_c;
    logic [16:0]            wet_c;
    logic [16:0]            dry_c;
    logic [TB-1:0]          lfo_i;
    logic [AW-1:0]          lfo_addr;
    logic [AW-1:0]          rom_addr;
    logic [GAIN_W-1:0]      rom_q;
    logic [16:0]            mag;
    logic [17:0]            u_sum;
    logic [16:0]            u_val;
    logic signed [W:0]      m_sum;
    logic [17:0]            g_sum;
    logic signed [OPW-1:0]  mul_a;
    logic signed [OPW-1:0]  mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   r17_full;
    logic signed [PW-1:0]   r16_full;
    logic signed [ACW-1:0]  acc_sum;
    logic signed [ACW-1:0]  acc_rnd;
    logic signed [W-1:0]    acc_sat;
    logic                   out_load;

    epap_sine_rom #(
        .TBL_BITS (TB)
    ) u_rom (
        .aclk    (aclk),
        .addr    (rom_addr),
        .rd_data (rom_q)
    );

    // apb port
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_PHASE_STEP:  prdata = 32'(phase_step_reg);
            REG_DEPTH_GAIN:  prdata = 32'(depth_reg);
            REG_START_PHASE: prdata = start_phase_reg;
            REG_WET_MIX:     prdata = 32'(wet_reg);
            REG_STEREO_MODE: prdata = 32'(stereo_reg);
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg  <= PHASE_STEP_RST;
            depth_reg       <= DEPTH_GAIN_RST;
            start_phase_reg <= START_PHASE_RST;
            wet_reg         <= WET_MIX_RST;
            stereo_reg      <= STEREO_MODE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PHASE_STEP:  phase_step_reg  <= pwdata[23:0];
                REG_DEPTH_GAIN:  depth_reg       <= pwdata[16:0];
                REG_START_PHASE: start_phase_reg <= pwdata;
                REG_WET_MIX:     wet_reg         <= pwdata[16:0];
                REG_STEREO_MODE: stereo_reg      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // operand conditioning
    assign depth_c = (depth_reg[16]) ? Q16_ONE : depth_reg;
    assign wet_c   = (wet_reg[16]) ? Q16_ONE : wet_reg;
    assign dry_c   = Q16_ONE - wet_c;

    assign lfo_i    = phase_reg[29 -: TB];
    assign lfo_addr = phase_reg[30] ? (TBL_N - AW'(lfo_i)) : AW'(lfo_i);

    assign mag   = prod_reg[32:16];
    assign u_sum = phase_reg[31] ? (18'(Q16_ONE) - 18'(mag)) : (18'(Q16_ONE) + 18'(mag));
    assign u_val = u_sum[17:1];

    assign m_sum = (W + 1)'(xl_reg) + (W + 1)'(xr_reg);
    assign g_sum = 18'(gr_reg) + 18'(rom_q);

    always_comb begin
        case (state_reg)
            ST_GR:   rom_addr = idx_reg;
            ST_GL:   rom_addr = TBL_N - idx_reg;
            default: rom_addr = lfo_addr;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LFO: begin
                mul_a = $signed(OPW'(rom_q));
                mul_b = $signed(OPW'(depth_c));
            end
            ST_GAIN: begin
                if (stereo_reg) begin
                    mul_a = OPW'(m_sum);
                    mul_b = $signed(OPW'(rom_q));
                end else begin
                    mul_a = $signed(OPW'(INV_SQRT2_Q16));
                    mul_b = $signed(OPW'(g_sum));
                end
            end
            ST_YL: begin
                mul_a = OPW'(m_sum);
                mul_b = $signed(OPW'(gr_reg));
            end
            ST_YR, ST_MY2: begin
                mul_a = $signed(OPW'(dry_c));
                mul_b = OPW'(xl_reg);
            end
            ST_L1: begin
                mul_a = $signed(OPW'(wet_c));
                mul_b = yl_reg;
            end
            ST_L2: begin
                mul_a = $signed(OPW'(dry_c));
                mul_b = OPW'(xr_reg);
            end
            ST_L3: begin
                mul_a = $signed(OPW'(wet_c));
                mul_b = yr_reg;
            end
            ST_MY1: begin
                mul_a = OPW'(xl_reg);
                mul_b = yl_reg;
            end
            default: begin
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // round half up and saturate
    assign r17_full = (prod_reg + HALF16) >>> 17;
    assign r16_full = (prod_reg + HALF15) >>> 16;
    assign acc_sum  = acc_reg + ACW'(prod_reg);
    assign acc_rnd  = (acc_reg + HALF_A) >>> 16;

    always_comb begin
        if (acc_rnd > SAT_HI) begin
            acc_sat = SAT_HI[W-1:0];
        end else if (acc_rnd < SAT_LO) begin
            acc_sat = SAT_LO[W-1:0];
        end else begin
            acc_sat = acc_rnd[W-1:0];
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LFO;
                end
            end
            ST_LFO:  state_next = ST_PAN;
            ST_PAN:  state_next = ST_GR;
            ST_GR:   state_next = ST_GL;
            ST_GL:   state_next = ST_GAIN;
            ST_GAIN: state_next = stereo_reg ? ST_YL : ST_MG;
            ST_YL:   state_next = ST_YR;
            ST_YR:   state_next = ST_L1;
            ST_L1:   state_next = ST_L2;
            ST_L2:   state_next = ST_L3;
            ST_L3:   state_next = stereo_reg ? ST_R1 : ST_DONE;
            ST_R1:   state_next = ST_R2;
            ST_R2:   state_next = ST_DONE;
            ST_MG:   state_next = ST_MY1;
            ST_MY1:  state_next = ST_MY2;
            ST_MY2:  state_next = ST_L1;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= START_PHASE_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && (cfg_idx == REG_START_PHASE)) begin
                phase_reg <= pwdata;
            end else if (out_load) begin
                phase_reg <= phase_reg + 32'(phase_step_reg);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        if (state_reg == ST_IDLE && s_valid) begin
            xl_reg   <= s_left_in;
            xr_reg   <= s_right_in;
            last_reg <= s_block_last;
        end
        case (state_reg)
            ST_PAN:  idx_reg <= u_val[16 -: AW];
            ST_GL:   gr_reg  <= rom_q;
            ST_YL:   yl_reg  <= r17_full[OPW-1:0];
            ST_YR:   yr_reg  <= r17_full[OPW-1:0];
            ST_MG:   yl_reg  <= r16_full[OPW-1:0];
            ST_MY2:  yl_reg  <= r16_full[OPW-1:0];
            ST_L1:   acc_reg <= ACW'(prod_reg);
            ST_L2:   acc_reg <= acc_sum;
            ST_L3: begin
                outl_reg <= acc_sat;
                outr_reg <= acc_sat;
                acc_reg  <= ACW'(prod_reg);
            end
            ST_R1:   acc_reg  <= acc_sum;
            ST_R2:   outr_reg <= acc_sat;
            default: begin
            end
        endcase
        if (out_load) begin
            m_left_reg  <= outl_reg;
            m_right_reg <= outr_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_left_out       = m_left_reg;
    assign m_right_out      = m_right_reg;
    assign m_block_last_out = m_last_reg;

endmodule

// File: rtl/epap_sine_rom.sv
// quarter-wave sine table with registered read
module epap_sine_rom #(
    parameter int TBL_BITS = 8
) (
    input  logic                         aclk,
    input  logic [TBL_BITS:0]            addr,
    output logic [epap_pkg::GAIN_W-1:0]  rd_data
);
    import epap_pkg::*;

    localparam int DEPTH = (1 << TBL_BITS) + 1;

    logic [GAIN_W-1:0] rom_mem [DEPTH];
    logic [GAIN_W-1:0] rd_data_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        assign rom_mem[k] = sine_entry(k, TBL_BITS);
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= rom_mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sim/testbench.sv
// self-checking testbench for the equal-power auto panner: lfo pan and mix prediction, apb setup
module testbench;

    localparam int TBL_BITS        = 8;
    localparam int TBL_N           = 1 << TBL_BITS;
    localparam int PHASES          = 14;
    localparam int WORDS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [epap_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } frame_t;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [epap_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [15:0]            s_left_in    = '0;
    logic signed [15:0]            s_right_in   = '0;
    logic                          s_block_last = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [15:0]            m_left_out;
    logic signed [15:0]            m_right_out;
    logic                          m_block_last_out;

    // register mirror and lfo state
    logic [23:0] cfg_step   = epap_pkg::PHASE_STEP_RST;
    logic [16:0] cfg_depth  = epap_pkg::DEPTH_GAIN_RST;
    logic [31:0] cfg_start  = epap_pkg::START_PHASE_RST;
    logic [16:0] cfg_wet    = epap_pkg::WET_MIX_RST;
    logic        cfg_stereo = epap_pkg::STEREO_MODE_RST;
    logic [31:0] lfo_phase  = epap_pkg::START_PHASE_RST;
    longint      sine_q16 [0:TBL_N];

    frame_t frames_to_send[$];
    frame_t panned_expected[$];
    bit     steady     = 1'b0;
    bit     held_once  = 1'b0;
    int     hold_left  = 0;
    int     words_seen = 0;
    int     mismatches = 0;

    equal_power_auto_panner dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_left_in        (s_left_in),
        .s_right_in       (s_right_in),
        .s_block_last     (s_block_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_out       (m_left_out),
        .m_right_out      (m_right_out),
        .m_block_last_out (m_block_last_out)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

    function automatic void build_sine();
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k <= TBL_N; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / 64'(TBL_N);
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 8192) >>> 14;
            if (sum > 65536) begin
                sum = 65536;
            end
            sine_q16[k] = sum;
        end
    endfunction

    function automatic longint rnd_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // pans one frame at the current lfo phase, then steps the lfo
    function automatic frame_t pan_frame(input logic signed [15:0] xl_in,
                                         input logic signed [15:0] xr_in,
                                         input logic last_in);
        frame_t      r;
        longint      xl, xr, depth, wet, dry, s, mag, pan, u, gl, gr, g, y;
        int unsigned q, i, idx;
        xl    = longint'(xl_in);
        xr    = longint'(xr_in);
        depth = (cfg_depth > 17'd65536) ? 65536 : longint'(cfg_depth);
        wet   = (cfg_wet > 17'd65536) ? 65536 : longint'(cfg_wet);
        dry   = 65536 - wet;
        q     = 32'(lfo_phase[31:30]);
        i     = 32'(lfo_phase[29:30-TBL_BITS]);
        s     = q[0] ? sine_q16[TBL_N - i] : sine_q16[i];
        if (q[1]) begin
            s = -s;
        end
        mag = (((s < 0) ? -s : s) * depth) >>> 16;
        pan = (s < 0) ? -mag : mag;
        u   = (pan + 65536) >>> 1;
        idx = 32'(u >>> (16 - TBL_BITS));
        if (idx > TBL_N) begin
            idx = TBL_N;
        end
        gr = sine_q16[idx];
        gl = sine_q16[TBL_N - idx];
        if (cfg_stereo) begin
            r.left  = sat16(rnd_shift(dry * xl + wet * rnd_shift((xl + xr) * gl, 17), 16));
            r.right = sat16(rnd_shift(dry * xr + wet * rnd_shift((xl + xr) * gr, 17), 16));
        end else begin
            g       = rnd_shift(46341 * (gl + gr), 16);
            y       = rnd_shift(xl * g, 16);
            r.left  = sat16(rnd_shift(dry * xl + wet * y, 16));
            r.right = r.left;
        end
        r.last    = last_in;
        lfo_phase = lfo_phase + 32'(cfg_step);
        return r;
    endfunction

    function automatic logic signed [15:0] extreme_sample(input int k);
        case (k)
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        if ($urandom_range(9) == 0) begin
            return extreme_sample($urandom_range(3));
        end
        return 16'($urandom);
    endfunction

    task automatic write_reg(input logic [epap_pkg::REG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            epap_pkg::REG_PHASE_STEP:  cfg_step   = data[23:0];
            epap_pkg::REG_DEPTH_GAIN:  cfg_depth  = data[16:0];
            epap_pkg::REG_START_PHASE: begin
                cfg_start = data;
                lfo_phase = data;
            end
            epap_pkg::REG_WET_MIX:     cfg_wet    = data[16:0];
            epap_pkg::REG_STEREO_MODE: cfg_stereo = data[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (frames_to_send.size() != 0 || s_valid || panned_expected.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // input side
    always @(posedge aclk) begin : drive_words
        frame_t f;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                panned_expected.push_back(pan_frame(s_left_in, s_right_in, s_block_last));
            end
            if (!s_valid || s_ready) begin
                if (frames_to_send.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
                    f = frames_to_send.pop_front();
                    s_valid      <= 1'b1;
                    s_left_in    <= f.left;
                    s_right_in   <= f.right;
                    s_block_last <= f.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge aclk) begin : check_words
        frame_t want;
        frame_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_left_out, m_right_out, m_block_last_out};
                if (panned_expected.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected word: got %0d %0d %0d",
                                 got.left, got.right, got.last);
                    end
                    mismatches++;
                end else begin
                    want = panned_expected.pop_front();
                    if (got.left !== want.left || got.right !== want.right
                        || got.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("word %0d mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     words_seen, want.left, want.right, want.last,
                                     got.left, got.right, got.last);
                        end
                        mismatches++;
                    end
                end
                words_seen++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && words_seen >= 430) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || $urandom_range(99) >= 35;
            end
        end
    end

    initial begin : run_phases
        logic [31:0] step_w, depth_w, start_w, wet_w, mode_w;
        frame_t      f;
        build_sine();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            steady = (p == 7);
            case (p)
                1: begin
                    step_w = 32'h00FF_FFFF; depth_w = 32'd65536; start_w = 32'hFFFF_FFFF;
                    wet_w  = 32'd65536;     mode_w  = 32'd0;
                end
                2: begin
                    step_w = 32'd0; depth_w = 32'd0; start_w = 32'd0;
                    wet_w  = 32'd0; mode_w  = 32'd1;
                end
                3: begin
                    step_w = 32'hFFFF_FFFF; depth_w = 32'h0001_FFFF; start_w = 32'h4000_0000;
                    wet_w  = 32'hFFFF_FFFF; mode_w  = 32'hFFFF_FFFE;
                end
                4: begin
                    step_w = 32'd0;     depth_w = 32'd65536; start_w = 32'h4000_0000;
                    wet_w  = 32'd65536; mode_w  = 32'd1;
                end
                5: begin
                    step_w = 32'd0;     depth_w = 32'd65536; start_w = 32'hC000_0000;
                    wet_w  = 32'd65536; mode_w  = 32'd0;
                end
                default: begin
                    step_w  = $urandom_range(1) ? $urandom_range(0, 1 << 20) : $urandom;
                    depth_w = $urandom_range(0, 70000);
                    start_w = $urandom;
                    wet_w   = $urandom_range(0, 70000);
                    mode_w  = $urandom_range(1);
                end
            endcase
            if (p != 0) begin
                write_reg(epap_pkg::REG_PHASE_STEP, step_w);
                write_reg(epap_pkg::REG_DEPTH_GAIN, depth_w);
                write_reg(epap_pkg::REG_START_PHASE, start_w);
                write_reg(epap_pkg::REG_WET_MIX, wet_w);
                write_reg(epap_pkg::REG_STEREO_MODE, mode_w);
            end
            if (p == 3) begin
                write_reg(REG_UNUSED, $urandom);
            end
            if (p == 0) begin
                for (int a = 0; a < 4; a++) begin
                    for (int b = 0; b < 4; b++) begin
                        f.left  = extreme_sample(a);
                        f.right = extreme_sample(b);
                        f.last  = 1'((a + b) % 2);
                        frames_to_send.push_back(f);
                    end
                end
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                f.left  = pick_sample();
                f.right = pick_sample();
                f.last  = 1'($urandom_range(1));
                frames_to_send.push_back(f);
            end
            wait_idle();
        end
        if (mismatches == 0 && panned_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/epap_pkg.sv
rtl/epap_sine_rom.sv
rtl/equal_power_auto_panner.sv
sim/testbench.sv
